### hw/rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int MAX_SEQUENCE_DEF = 7;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Event codes on the input channel.
  typedef enum logic [1:0] {
    ACT_NET     = 2'd0,
    ACT_RX      = 2'd1,
    ACT_CHKERR  = 2'd2,
    ACT_TIMEOUT = 2'd3
  } gbn_action_t;

  // Result codes on the output channel.
  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_STATUS  = 2'd3
  } gbn_kind_t;

  // Datapath operations selected by a control word.
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_LATCH    = 3'd1,
    OP_SEND_NEW = 3'd2,
    OP_STATUS   = 3'd3,
    OP_DELIVER  = 3'd4,
    OP_RELEASE  = 3'd5,
    OP_REWIND   = 3'd6,
    OP_RESEND   = 3'd7
  } gbn_op_t;

  // Branch conditions. When the condition holds, the step jumps and does nothing else.
  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_NO_ITEM     = 3'd1,
    C_ACT_RX      = 3'd2,
    C_ACT_TMO     = 3'd3,
    C_NET_SKIP    = 3'd4,
    C_SEQ_MISS    = 3'd5,
    C_REL_DONE    = 3'd6,
    C_RESEND_DONE = 3'd7
  } gbn_cond_t;

  typedef enum logic [1:0] {
    NX_SEQ  = 2'd0,
    NX_SELF = 2'd1,
    NX_IDLE = 2'd2
  } gbn_next_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] gbn_step_t;

  localparam gbn_step_t STEP_IDLE       = gbn_step_t'(0);
  localparam gbn_step_t STEP_DISP_RX    = gbn_step_t'(1);
  localparam gbn_step_t STEP_DISP_TMO   = gbn_step_t'(2);
  localparam gbn_step_t STEP_NET_CHECK  = gbn_step_t'(3);
  localparam gbn_step_t STEP_NET_SEND   = gbn_step_t'(4);
  localparam gbn_step_t STEP_STATUS     = gbn_step_t'(5);
  localparam gbn_step_t STEP_RX_DELIVER = gbn_step_t'(6);
  localparam gbn_step_t STEP_RX_RELEASE = gbn_step_t'(7);
  localparam gbn_step_t STEP_TMO_REWIND = gbn_step_t'(8);
  localparam gbn_step_t STEP_TMO_RESEND = gbn_step_t'(9);

  typedef struct packed {
    gbn_cond_t cond;
    gbn_step_t target;
    gbn_op_t   op;
    logic      emit;
    gbn_next_t next;
  } gbn_uword_t;

  // Condition inputs from the datapath to the sequencer.
  typedef struct packed {
    logic no_item;
    logic act_rx;
    logic act_tmo;
    logic net_skip;
    logic seq_miss;
    logic rel_done;
    logic resend_done;
  } gbn_flags_t;

  // The control program.
  function automatic gbn_uword_t ucode(input gbn_step_t step);
    gbn_uword_t w;
    unique case (step)
      STEP_IDLE:       w = '{C_NO_ITEM,     STEP_IDLE,       OP_LATCH,    1'b0, NX_SEQ};
      STEP_DISP_RX:    w = '{C_ACT_RX,      STEP_RX_DELIVER, OP_NONE,     1'b0, NX_SEQ};
      STEP_DISP_TMO:   w = '{C_ACT_TMO,     STEP_TMO_REWIND, OP_NONE,     1'b0, NX_SEQ};
      STEP_NET_CHECK:  w = '{C_NET_SKIP,    STEP_STATUS,     OP_NONE,     1'b0, NX_SEQ};
      STEP_NET_SEND:   w = '{C_NEVER,       STEP_IDLE,       OP_SEND_NEW, 1'b1, NX_SEQ};
      STEP_STATUS:     w = '{C_NEVER,       STEP_IDLE,       OP_STATUS,   1'b1, NX_IDLE};
      STEP_RX_DELIVER: w = '{C_SEQ_MISS,    STEP_RX_RELEASE, OP_DELIVER,  1'b1, NX_SEQ};
      STEP_RX_RELEASE: w = '{C_REL_DONE,    STEP_STATUS,     OP_RELEASE,  1'b1, NX_SELF};
      STEP_TMO_REWIND: w = '{C_NEVER,       STEP_IDLE,       OP_REWIND,   1'b0, NX_SEQ};
      STEP_TMO_RESEND: w = '{C_RESEND_DONE, STEP_STATUS,     OP_RESEND,   1'b1, NX_SELF};
      default:         w = '{C_NEVER,       STEP_IDLE,       OP_NONE,     1'b0, NX_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/go_back_n_link_endpoint.sv
// Go-back-N data link endpoint.
// Input channel (in_valid/in_stall): one beat is one event: a packet from the
// network layer, an arriving frame, a checksum error, or a timeout. The block
// holds in_stall high from the beat after an event is accepted until its final
// status beat has been loaded into the output register.
//
// Output channel (out_valid/out_stall): each event yields its results in order,
// closed by exactly one status beat with last set. A packet that fits the window
// yields one send beat, an arriving frame an optional deliver beat plus one
// release beat per acked frame, a timeout one send beat per outstanding frame.
//
// Timing: a microcoded sequencer steps one control word per cycle and loads at
// most one result per cycle while the output does not stall. Every event first
// passes the dispatch steps; a checksum error or a packet refused by a full
// window then goes to the status step, a sent packet through a send step, an
// arriving frame through a deliver step and a release step per released frame,
// and a timeout through a rewind step and a resend step per resent frame.
// When out_stall is high the current result stays in the output register and
// the sequencer halts on the step that wants to produce the next one. Reset
// clears the sequence counters and returns the sequencer to its idle step; the
// window store is not cleared, since a frame is only read after it was written.
module go_back_n_link_endpoint
  import gbn_pkg::*;
#(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int SEQ_W = $clog2(MAX_SEQUENCE + 1)
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic [PAYLOAD_BITS-1:0] net_payload,
  input  logic [SEQ_W-1:0]        rx_seq,
  input  logic [SEQ_W-1:0]        rx_ack,
  input  logic [PAYLOAD_BITS-1:0] rx_payload,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [SEQ_W-1:0]        frame_seq,
  output logic [SEQ_W-1:0]        frame_ack,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    network_enable,
  output logic                    last
);

  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(MAX_SEQUENCE);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_MAX) ? '0 : s + SEQ_W'(1);
  endfunction

  // Sequence counters.
  logic [SEQ_W-1:0] next_to_send, next_to_send_next;
  logic [SEQ_W-1:0] oldest_unacked, oldest_unacked_next;
  logic [SEQ_W-1:0] expected_rx_seq, expected_rx_seq_next;
  logic [SEQ_W-1:0] outstanding_count, outstanding_count_next;
  logic [SEQ_W-1:0] resend_idx, resend_idx_next;

  // The event being worked on.
  gbn_action_t             act_q;
  logic [PAYLOAD_BITS-1:0] net_q;
  logic [SEQ_W-1:0]        rx_seq_q;
  logic [SEQ_W-1:0]        rx_ack_q;
  logic [PAYLOAD_BITS-1:0] rx_pay_q;

  // Window store: one frame per sequence number, registered read ahead of use.
  logic [PAYLOAD_BITS-1:0] window_store [0:MAX_SEQUENCE];
  logic [PAYLOAD_BITS-1:0] rd_data;

  gbn_flags_t flags;
  gbn_op_t    op;
  logic       fire;
  logic       emit;
  logic       idle;
  logic       blocked;
  logic       window_full;
  logic       ack_in_window;
  logic [SEQ_W-1:0] ack_to_send;

  gbn_kind_t               kind_next;
  logic [SEQ_W-1:0]        frame_seq_next;
  logic [SEQ_W-1:0]        frame_ack_next;
  logic [PAYLOAD_BITS-1:0] payload_next;
  logic                    network_enable_next;
  logic                    last_next;

  gbn_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .flags   (flags),
    .blocked (blocked),
    .op      (op),
    .fire    (fire),
    .emit    (emit),
    .idle    (idle)
  );

  // Events are only taken while the sequencer sits on its idle step.
  assign in_stall = !idle;
  assign blocked  = out_valid && out_stall;

  assign window_full = (outstanding_count >= SEQ_MAX);
  // The ack acknowledges the frames from the oldest unacknowledged one up to it,
  // provided it lies inside the window that wraps modulo MAX_SEQUENCE + 1.
  assign ack_in_window =
      ((oldest_unacked <= rx_ack_q) && (rx_ack_q < next_to_send)) ||
      ((next_to_send < oldest_unacked) && (oldest_unacked <= rx_ack_q)) ||
      ((rx_ack_q < next_to_send) && (next_to_send < oldest_unacked));
  // Sent frames carry the number of the last frame received in sequence.
  assign ack_to_send = (expected_rx_seq == '0) ? SEQ_MAX : expected_rx_seq - SEQ_W'(1);

  always_comb begin
    flags.no_item     = !in_valid;
    flags.act_rx      = (act_q == ACT_RX);
    flags.act_tmo     = (act_q == ACT_TIMEOUT);
    flags.net_skip    = (act_q == ACT_CHKERR) || window_full;
    flags.seq_miss    = (rx_seq_q != expected_rx_seq);
    flags.rel_done    = (rx_ack_q > SEQ_MAX) || (outstanding_count == '0) || !ack_in_window;
    flags.resend_done = (resend_idx >= outstanding_count);
  end

  // Counter updates and the beat each operation produces.
  always_comb begin
    next_to_send_next      = next_to_send;
    oldest_unacked_next    = oldest_unacked;
    expected_rx_seq_next   = expected_rx_seq;
    outstanding_count_next = outstanding_count;
    resend_idx_next        = resend_idx;

    kind_next           = KIND_STATUS;
    frame_seq_next      = '0;
    frame_ack_next      = '0;
    payload_next        = '0;
    network_enable_next = 1'b0;
    last_next           = 1'b0;

    case (op)
      OP_SEND_NEW: begin
        kind_next      = KIND_SEND;
        frame_seq_next = next_to_send;
        frame_ack_next = ack_to_send;
        payload_next   = net_q;
        if (fire) begin
          outstanding_count_next = outstanding_count + SEQ_W'(1);
          next_to_send_next      = seq_inc(next_to_send);
        end
      end
      OP_STATUS: begin
        kind_next           = KIND_STATUS;
        network_enable_next = !window_full;
        last_next           = 1'b1;
      end
      OP_DELIVER: begin
        kind_next    = KIND_DELIVER;
        payload_next = rx_pay_q;
        if (fire) begin
          expected_rx_seq_next = seq_inc(expected_rx_seq);
        end
      end
      OP_RELEASE: begin
        kind_next      = KIND_RELEASE;
        frame_seq_next = oldest_unacked;
        if (fire) begin
          outstanding_count_next = outstanding_count - SEQ_W'(1);
          oldest_unacked_next    = seq_inc(oldest_unacked);
        end
      end
      OP_REWIND: begin
        if (fire) begin
          next_to_send_next = oldest_unacked;
          resend_idx_next   = '0;
        end
      end
      OP_RESEND: begin
        kind_next      = KIND_SEND;
        frame_seq_next = next_to_send;
        frame_ack_next = ack_to_send;
        payload_next   = rd_data;
        if (fire) begin
          next_to_send_next = seq_inc(next_to_send);
          resend_idx_next   = resend_idx + SEQ_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_to_send      <= '0;
      oldest_unacked    <= '0;
      expected_rx_seq   <= '0;
      outstanding_count <= '0;
      resend_idx        <= '0;
      out_valid         <= 1'b0;
    end else begin
      next_to_send      <= next_to_send_next;
      oldest_unacked    <= oldest_unacked_next;
      expected_rx_seq   <= expected_rx_seq_next;
      outstanding_count <= outstanding_count_next;
      resend_idx        <= resend_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && op == OP_LATCH) begin
      act_q    <= gbn_action_t'(action);
      net_q    <= net_payload;
      rx_seq_q <= rx_seq;
      rx_ack_q <= rx_ack;
      rx_pay_q <= rx_payload;
    end
    if (emit) begin
      kind           <= kind_next;
      frame_seq      <= frame_seq_next;
      frame_ack      <= frame_ack_next;
      payload        <= payload_next;
      network_enable <= network_enable_next;
      last           <= last_next;
    end
  end

  // The frame is stored as it is first sent. The read port is registered and
  // addressed by the next send pointer, so that a resend finds its data ready.
  always_ff @(posedge clk) begin
    if (fire && op == OP_SEND_NEW) begin
      window_store[next_to_send] <= net_q;
    end
    rd_data <= window_store[next_to_send_next];
  end

endmodule

### hw/rtl/gbn_sequencer.sv
module gbn_sequencer
  import gbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  gbn_flags_t flags,
  input  logic       blocked,
  output gbn_op_t    op,
  output logic       fire,
  output logic       emit,
  output logic       idle
);

  gbn_step_t  pc;
  gbn_step_t  pc_next;
  gbn_uword_t word;
  logic       taken;

  always_comb begin
    word = ucode(pc);
    unique case (word.cond)
      C_NEVER:       taken = 1'b0;
      C_NO_ITEM:     taken = flags.no_item;
      C_ACT_RX:      taken = flags.act_rx;
      C_ACT_TMO:     taken = flags.act_tmo;
      C_NET_SKIP:    taken = flags.net_skip;
      C_SEQ_MISS:    taken = flags.seq_miss;
      C_REL_DONE:    taken = flags.rel_done;
      C_RESEND_DONE: taken = flags.resend_done;
      default:       taken = 1'b0;
    endcase
    // A step that produces a beat waits while the output register is held.
    fire = !taken && !(word.emit && blocked);
    emit = fire && word.emit;
    op   = word.op;
    idle = (pc == STEP_IDLE);

    if (taken) begin
      pc_next = word.target;
    end else if (!fire) begin
      pc_next = pc;
    end else begin
      unique case (word.next)
        NX_SEQ:  pc_next = pc + gbn_step_t'(1);
        NX_SELF: pc_next = pc;
        NX_IDLE: pc_next = STEP_IDLE;
        default: pc_next = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hw/rtl/gbn_checker.sv
module gbn_checker
  import gbn_pkg::*;
#(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int SEQ_W = $clog2(MAX_SEQUENCE + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              kind,
  input logic [SEQ_W-1:0]        frame_seq,
  input logic [PAYLOAD_BITS-1:0] payload,
  input logic                    network_enable,
  input logic                    last
);

  // An accepted event always keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // Only the status beat closes an event and only it carries the enable flag.
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((last == (kind == KIND_STATUS)) && (!network_enable || last)))
    else $error("status and last disagree");

  // No new event is taken while an earlier one still has results to produce.
  a_no_accept_mid_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("event accepted before the previous one finished");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(kind) && $stable(frame_seq) && $stable(payload)))
    else $error("stalled beat changed");

endmodule

bind go_back_n_link_endpoint gbn_checker #(
  .MAX_SEQUENCE (MAX_SEQUENCE),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_gbn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .frame_seq      (frame_seq),
  .payload        (payload),
  .network_enable (network_enable),
  .last           (last)
);
